// File: rtl/bbpp_pkg.sv
// Package for the bit-bang protection port.
// Holds function, line event and link state codes, register index and bit position constants, and the line classifier.
// No dependencies.
`default_nettype none

package bbpp_pkg;

    localparam int REG_COUNT = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LINES = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT = 2'd3;

    localparam int MODE_BIT = 4;
    localparam int CLK_BIT  = 5;
    localparam int DAT_BIT  = 4;
    localparam int OUT_BIT  = 4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        EV_LO   = 2'd0,
        EV_HI   = 2'd1,
        EV_RISE = 2'd2,
        EV_FALL = 2'd3
    } t_event;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ADDR = 5'b00010,
        ST_DATA = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_DONE = 5'b10000
    } t_link;

    function automatic t_event classify(input logic cur, input logic prev);
        t_event ev;
        if (cur && !prev) begin
            ev = EV_RISE;
        end else if (!cur && prev) begin
            ev = EV_FALL;
        end else if (cur) begin
            ev = EV_HI;
        end else begin
            ev = EV_LO;
        end
        return ev;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bit_bang_protection_port_unit.sv
// Bit-bang protection port: I2C-like serial device behind four byte registers.
// The result of an accepted transaction appears on o_read_data in the next cycle.
// Throughput: one transaction per cycle; a new transaction enters whenever the
// output register is empty or its result is taken in the same cycle.
// Reset: synchronous, active low; clears all registers but o_read_data, and sets the link to idle.
// Depends on bbpp_pkg.
`default_nettype none

module bit_bang_protection_port_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_func,
    input  wire logic [1:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_read_data
);
    import bbpp_pkg::*;

    logic [7:0] r_regs [REG_COUNT];
    logic       r_clk_prev;
    t_event     r_clk_ev;
    t_event     r_clk_ev_prev;
    logic       r_dat_prev;
    t_event     r_dat_ev;
    logic [3:0] r_bit_cnt;
    logic [7:0] r_shift;
    t_link      r_link_state;
    logic [7:0] r_resp;
    logic       r_out_valid;
    logic [7:0] r_read_data;

    logic [7:0] n_regs [REG_COUNT];
    logic       n_clk_prev;
    t_event     n_clk_ev;
    t_event     n_clk_ev_prev;
    logic       n_dat_prev;
    t_event     n_dat_ev;
    logic [3:0] n_bit_cnt;
    logic [7:0] n_shift;
    t_link      n_link_state;
    logic [7:0] n_resp;
    logic [7:0] n_read_data;

    logic       w_accept;
    logic       w_write_mode;
    logic       w_clk;
    logic       w_dat;
    logic [7:0] w_neg;

    assign o_stall     = r_out_valid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;

    always_comb begin
        n_regs        = r_regs;
        n_clk_prev    = r_clk_prev;
        n_clk_ev      = r_clk_ev;
        n_clk_ev_prev = r_clk_ev_prev;
        n_dat_prev    = r_dat_prev;
        n_dat_ev      = r_dat_ev;
        n_bit_cnt     = r_bit_cnt;
        n_shift       = r_shift;
        n_link_state  = r_link_state;
        n_resp        = r_resp;
        n_read_data   = 8'd0;
        w_write_mode  = 1'b0;
        w_clk         = 1'b0;
        w_dat         = 1'b0;
        w_neg         = 8'd0 - r_shift;

        if (t_func'(i_func) == FUNC_WRITE) begin
            n_regs[i_reg_index] = i_write_data;
            w_write_mode        = n_regs[REG_MODE][MODE_BIT];
            w_clk               = n_regs[REG_LINES][CLK_BIT];
            w_dat               = n_regs[REG_LINES][DAT_BIT];
            n_clk_ev            = classify(w_clk, r_clk_prev);
            n_clk_prev          = w_clk;
            n_dat_ev            = classify(w_dat, r_dat_prev);
            n_dat_prev          = w_dat;
            n_clk_ev_prev       = n_clk_ev;

            if (w_write_mode) begin
                if (r_link_state == ST_IDLE && n_clk_ev == EV_HI && n_dat_ev == EV_FALL) begin
                    n_link_state = ST_ADDR;
                    n_bit_cnt    = 4'd0;
                    n_shift      = 8'd0;
                end else if (r_link_state == ST_WAIT && n_clk_ev == EV_HI
                             && n_dat_ev == EV_RISE) begin
                    n_link_state = ST_DONE;
                    n_bit_cnt    = 4'd0;
                    n_shift      = 8'd0;
                end else if (n_clk_ev == EV_FALL && r_clk_ev_prev == EV_RISE) begin
                    if (r_bit_cnt < BITS_PER_BYTE) begin
                        n_shift   = {r_shift[6:0], w_dat};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                    end else begin
                        case (r_link_state)
                            ST_ADDR: begin
                                n_link_state = ST_DATA;
                                n_bit_cnt    = 4'd0;
                                n_shift      = 8'd0;
                            end
                            ST_DATA: begin
                                n_resp       = {w_neg[3:0], w_neg[7:4]};
                                n_link_state = ST_WAIT;
                                n_bit_cnt    = 4'd0;
                                n_shift      = 8'd0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end else begin
                if (r_link_state == ST_DONE && n_clk_ev == EV_HI && n_dat_ev == EV_RISE) begin
                    n_link_state = ST_IDLE;
                    n_bit_cnt    = 4'd0;
                    n_shift      = 8'd0;
                end
            end
        end else begin
            if (r_link_state == ST_DONE && r_clk_ev == EV_RISE && i_reg_index == REG_SHIFT) begin
                if (r_bit_cnt < BITS_PER_BYTE) begin
                    n_read_data[OUT_BIT] = r_resp[~r_bit_cnt[2:0]];
                    n_bit_cnt            = r_bit_cnt + 4'd1;
                end else begin
                    n_bit_cnt = 4'd0;
                end
            end else begin
                n_read_data = r_regs[i_reg_index];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs        <= '{default: 8'd0};
            r_clk_prev    <= 1'b0;
            r_clk_ev      <= EV_LO;
            r_clk_ev_prev <= EV_LO;
            r_dat_prev    <= 1'b0;
            r_dat_ev      <= EV_LO;
            r_bit_cnt     <= 4'd0;
            r_shift       <= 8'd0;
            r_link_state  <= ST_IDLE;
            r_resp        <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_regs        <= n_regs;
                r_clk_prev    <= n_clk_prev;
                r_clk_ev      <= n_clk_ev;
                r_clk_ev_prev <= n_clk_ev_prev;
                r_dat_prev    <= n_dat_prev;
                r_dat_ev      <= n_dat_ev;
                r_bit_cnt     <= n_bit_cnt;
                r_shift       <= n_shift;
                r_link_state  <= n_link_state;
                r_resp        <= n_resp;
                r_out_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data <= n_read_data;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= BITS_PER_BYTE)
        else $error("Bit counter exceeds one byte.");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_func == FUNC_WRITE |=> r_out_valid && r_read_data == 8'd0)
        else $error("Write transaction did not return zero.");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && i_func == FUNC_WRITE) |=> $stable(r_link_state) && $stable(r_shift))
        else $error("Link state changed without a write transaction.");

    a_enter_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_link_state != r_link_state |=> r_bit_cnt == 4'd0 && r_shift == 8'd0)
        else $error("State change did not clear the bit counter and shift byte.");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for bit_bang_protection_port_unit.
// Drives register transactions, predicts every read result, checks in order.
// Depends on bbpp_pkg and the unit under test.
module tb;
    import bbpp_pkg::*;

    localparam int ITEM_TARGET    = 1850;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 90;

    typedef struct {
        bit         sync;
        t_func      func;
        logic [1:0] idx;
        logic [7:0] data;
    } port_access_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_func = 1'b0;
    logic [1:0] i_reg_index = 2'd0;
    logic [7:0] i_write_data = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_read_data;

    bit_bang_protection_port_unit dut (.*);

    always #4 i_clk = ~i_clk;

    port_access_t access_q[$];
    logic [7:0]   read_data_q[$];

    int unsigned planned = 0;
    int unsigned total_planned = 32'hFFFF_FFFF;
    int unsigned transfers = 0;
    int unsigned sent_count = 0;
    int unsigned checked_count = 0;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic [7:0]  predicted;
    logic [7:0]  wanted;

    wire quiet     = sent_count + QUIET_TAIL >= total_planned;
    wire idling_on = ((sent_count / 200) % 3) != 2;

    // Device state as the predictor sees it.
    logic [7:0] mirror_regs [REG_COUNT] = '{default: 8'h00};
    logic       clk_prev_lvl = 1'b0;
    logic       dat_prev_lvl = 1'b0;
    t_event     clk_ev = EV_LO;
    t_event     clk_ev_last = EV_LO;
    t_event     dat_ev = EV_LO;
    logic [3:0] bit_cnt = 4'd0;
    logic [7:0] shift_reg = 8'h00;
    t_link      link = ST_IDLE;
    logic [7:0] resp = 8'h00;

    function automatic t_event line_event(input logic now_lvl, input logic was_lvl);
        case ({now_lvl, was_lvl})
            2'b10: return EV_RISE;
            2'b01: return EV_FALL;
            2'b11: return EV_HI;
            default: return EV_LO;
        endcase
    endfunction

    task automatic enter_link(input t_link next_link);
        link = next_link;
        bit_cnt = 4'd0;
        shift_reg = 8'h00;
    endtask

    task automatic predict_port_access(input t_func fn, input logic [1:0] idx,
                                       input logic [7:0] wd, output logic [7:0] rd);
        logic       wmode;
        logic       clk;
        logic       dat;
        logic [7:0] neg;
        rd = 8'h00;
        if (fn == FUNC_READ) begin
            if (link == ST_DONE && clk_ev == EV_RISE && idx == REG_SHIFT) begin
                if (bit_cnt < BITS_PER_BYTE) begin
                    rd[OUT_BIT] = resp[3'd7 - bit_cnt[2:0]];
                    bit_cnt = bit_cnt + 4'd1;
                end else begin
                    bit_cnt = 4'd0;
                end
            end else begin
                rd = mirror_regs[idx];
            end
        end else begin
            mirror_regs[idx] = wd;
            wmode = mirror_regs[REG_MODE][MODE_BIT];
            clk = mirror_regs[REG_LINES][CLK_BIT];
            dat = mirror_regs[REG_LINES][DAT_BIT];
            clk_ev = line_event(clk, clk_prev_lvl);
            clk_prev_lvl = clk;
            dat_ev = line_event(dat, dat_prev_lvl);
            dat_prev_lvl = dat;
            if (wmode) begin
                if (link == ST_IDLE && clk_ev == EV_HI && dat_ev == EV_FALL) begin
                    enter_link(ST_ADDR);
                end else if (link == ST_WAIT && clk_ev == EV_HI && dat_ev == EV_RISE) begin
                    enter_link(ST_DONE);
                end else if (clk_ev == EV_FALL && clk_ev_last == EV_RISE) begin
                    if (bit_cnt < BITS_PER_BYTE) begin
                        shift_reg = {shift_reg[6:0], dat};
                        bit_cnt = bit_cnt + 4'd1;
                    end else if (link == ST_ADDR) begin
                        enter_link(ST_DATA);
                    end else if (link == ST_DATA) begin
                        neg = 8'h00 - shift_reg;
                        resp = {neg[3:0], neg[7:4]};
                        enter_link(ST_WAIT);
                    end
                end
            end else if (link == ST_DONE && clk_ev == EV_HI && dat_ev == EV_RISE) begin
                enter_link(ST_IDLE);
            end
            clk_ev_last = clk_ev;
        end
    endtask

    task automatic put_access(input bit sync, input t_func fn, input logic [1:0] idx,
                              input logic [7:0] data);
        port_access_t a;
        a.sync = sync;
        a.func = fn;
        a.idx = idx;
        a.data = data;
        access_q.push_back(a);
        if (!sync) begin
            planned++;
        end
    endtask

    task automatic put_write(input logic [1:0] idx, input logic [7:0] data);
        put_access(1'b0, FUNC_WRITE, idx, data);
    endtask

    task automatic put_read(input logic [1:0] idx);
        put_access(1'b0, FUNC_READ, idx, 8'($urandom));
    endtask

    task automatic put_sync();
        put_access(1'b1, FUNC_READ, REG_MODE, 8'h00);
    endtask

    task automatic set_lines(input logic clk, input logic dat);
        logic [7:0] v;
        v = 8'($urandom);
        v[CLK_BIT] = clk;
        v[DAT_BIT] = dat;
        put_write(REG_LINES, v);
    endtask

    task automatic set_mode(input logic wmode);
        logic [7:0] v;
        v = 8'($urandom);
        v[MODE_BIT] = wmode;
        put_write(REG_MODE, v);
    endtask

    task automatic clock_bit(input logic b);
        set_lines(1'b0, b);
        set_lines(1'b1, b);
        set_lines(1'b0, b);
    endtask

    task automatic send_byte(input logic [7:0] v);
        for (int i = 7; i >= 0; i--) begin
            clock_bit(v[i]);
        end
        clock_bit(1'($urandom_range(0, 1)));
    endtask

    // Walks any link state back to idle: enough clocks to finish both bytes,
    // a stop in write mode, then a stop in read mode.
    task automatic flush_link();
        set_mode(1'b1);
        repeat (18) clock_bit(1'($urandom_range(0, 1)));
        set_lines(1'b0, 1'b0);
        set_lines(1'b1, 1'b0);
        set_lines(1'b1, 1'b1);
        set_mode(1'b0);
        set_lines(1'b1, 1'b0);
        set_lines(1'b1, 1'b1);
    endtask

    task automatic run_transfer();
        int n;
        set_mode(1'b1);
        set_lines(1'b1, 1'b1);
        set_lines(1'b1, 1'b0);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        set_lines(1'b0, 1'b0);
        set_lines(1'b1, 1'b0);
        set_lines(1'b1, 1'b1);
        set_mode(1'b0);
        set_lines(1'b0, 1'b1);
        set_lines(1'b1, 1'b1);
        n = $urandom_range(0, 12);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
                put_read(2'($urandom_range(0, 2)));
            end else begin
                put_read(REG_SHIFT);
            end
        end
        set_lines(1'b1, 1'b0);
        set_lines(1'b1, 1'b1);
        transfers++;
    endtask

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("tb: mismatch: %s", what);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_port_access(t_func'(i_func), i_reg_index, i_write_data, predicted);
                read_data_q.push_back(predicted);
                sent_count++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (!quiet && idling_on && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    i_valid <= 1'b0;
                end else if (access_q.size() > 0 && access_q[0].sync) begin
                    if (read_data_q.size() == 0) begin
                        void'(access_q.pop_front());
                    end
                    i_valid <= 1'b0;
                end else if (access_q.size() > 0) begin
                    i_func <= access_q[0].func;
                    i_reg_index <= access_q[0].idx;
                    i_write_data <= access_q[0].data;
                    void'(access_q.pop_front());
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (read_data_q.size() == 0) begin
                    flag_error($sformatf("unexpected result read_data=%02h", o_read_data));
                end else begin
                    wanted = read_data_q.pop_front();
                    if (o_read_data !== wanted) begin
                        flag_error($sformatf("read_data expected %02h actual %02h",
                                             wanted, o_read_data));
                    end
                end
                checked_count++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && checked_count >= 400) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && idling_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        bit mid_sync_done;
        int kind;
        mid_sync_done = 1'b0;

        for (int r = 0; r < REG_COUNT; r++) begin
            put_read(2'(r));
        end
        for (int r = 0; r < REG_COUNT; r++) begin
            put_write(2'(r), 8'hFF);
            put_read(2'(r));
        end
        for (int r = 0; r < REG_COUNT; r++) begin
            put_write(2'(r), 8'h00);
            put_read(2'(r));
        end
        // Bits are captured in write mode even while the link is idle.
        set_mode(1'b1);
        clock_bit(1'b1);
        put_sync();

        while (planned < ITEM_TARGET) begin
            if (!mid_sync_done && planned >= ITEM_TARGET / 2) begin
                put_sync();
                mid_sync_done = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                run_transfer();
            end else if (kind == 7) begin
                repeat ($urandom_range(5, 30)) begin
                    put_access(1'b0, t_func'($urandom_range(0, 1)),
                               2'($urandom_range(0, 3)), 8'($urandom));
                end
                flush_link();
            end else if (kind == 8) begin
                set_mode(1'b1);
                set_lines(1'b1, 1'b1);
                set_lines(1'b1, 1'b0);
                repeat ($urandom_range(0, 17)) clock_bit(1'($urandom_range(0, 1)));
                flush_link();
            end else begin
                run_transfer();
                repeat ($urandom_range(1, 4)) put_read(2'($urandom_range(0, 3)));
            end
        end
        total_planned = planned;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (access_q.size() != 0 || i_valid || read_data_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);

        $display("tb: %0d transactions driven, %0d results checked, %0d full transfers",
                 sent_count, checked_count, transfers);
        $display("tb: %0d mismatches; one long output hold, two drain pauses", error_count);
        if (error_count == 0 && read_data_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
